FILE: rtl/core/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants of the FIFO cache replacement unit: field widths,
// event codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package fcr_pkg;

   // input and output field widths
   localparam int FUNC_W   = 1;
   localparam int IDX_W    = 6;
   localparam int WAYF_W   = 3;
   localparam int REQ_W    = FUNC_W + IDX_W + WAYF_W;
   localparam int REQ_TD_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_TD_W = 8;

   // event codes
   localparam logic [FUNC_W-1:0] FUNC_ACCESS = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_EVICT  = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } fcr_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic update;
   } fcr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } fcr_status_type;

endpackage

FILE: rtl/core/fifo_cache_replacement_unit.sv
// ----------------------------------------------------------------------------
// fifo_cache_replacement_unit
// Per-set FIFO replacement state for a set-associative cache. An eviction
// moves the way to the back of its set's list; every event returns the way
// now at the front, the next victim, or zero for a set out of range.
// Result: the row is read into the RAM read register as the event word is
// accepted; the update step, which waits while the previous result still
// waits on rsp_tready, then loads the result register. No new event is taken
// until that step ends, as the row's read-modify-write goes through the
// single read and write port of the order RAM. Reset: a clearing pass writes
// the initial order to every set; req_tready stays low until it ends.
// ----------------------------------------------------------------------------
module fifo_cache_replacement_unit #(
   parameter int NUM_SETS = 64,
   parameter int WAYS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // func [0], set_index [6:1], way [9:7], zero fill above
   input  logic [fcr_pkg::REQ_TD_W-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // victim_way [2:0], zero fill above
   output logic [fcr_pkg::RSP_TD_W-1:0]  rsp_tdata
);

   fcr_pkg::fcr_cmd_type           cmd;
   fcr_pkg::fcr_status_type        status;
   logic [fcr_pkg::WAYF_W-1:0]     victim_way;

   // controller
   fcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   fcr_dpath #(
      .NUM_SETS(NUM_SETS),
      .WAYS    (WAYS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_tdata[0]),
      .req_set_index (req_tdata[6:1]),
      .req_way       (req_tdata[9:7]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_victim_way(victim_way)
   );

   assign rsp_tdata = {{(fcr_pkg::RSP_TD_W - fcr_pkg::WAYF_W){1'b0}}, victim_way};

   // one event at a time: no accept right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("event accepted while previous one in flight");

   // clearing pass blocks input after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input ready during clearing pass");

   // a result is only loaded on the update step
   a_update_gated: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (status.out_free && !req_tready))
      else $error("result loaded outside update step");

   // victim is always a legal way
   a_victim_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((WAYS > 8) || (32'(victim_way) < WAYS)))
      else $error("victim way out of range");

endmodule

FILE: rtl/core/fcr_ram.sv
// ----------------------------------------------------------------------------
// fcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/fcr_ctrl.sv
// ----------------------------------------------------------------------------
// fcr_ctrl
// Controller: runs the clearing pass after reset, then takes one event at a
// time through a read and an update/write-back step.
// ----------------------------------------------------------------------------
module fcr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  fcr_pkg::fcr_status_type status,
   output fcr_pkg::fcr_cmd_type   cmd
);

   fcr_pkg::fcr_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.clear_step = 1'b0;
      cmd.capture    = 1'b0;
      cmd.update     = 1'b0;
      req_tready     = 1'b0;
      case (state_ff)
         fcr_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = fcr_pkg::ST_IDLE;
            end
         end
         fcr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = fcr_pkg::ST_UPDATE;
            end
         end
         fcr_pkg::ST_UPDATE: begin
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = fcr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcr_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

FILE: rtl/core/fcr_dpath.sv
// ----------------------------------------------------------------------------
// fcr_dpath
// Datapath: per-set way order rows in RAM, move-to-back update of the row,
// clearing counter and the result register.
// ----------------------------------------------------------------------------
module fcr_dpath #(
   parameter int NUM_SETS = 64,
   parameter int WAYS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fcr_pkg::fcr_cmd_type            cmd,
   output fcr_pkg::fcr_status_type         status,
   input  logic [fcr_pkg::FUNC_W-1:0]      req_func,
   input  logic [fcr_pkg::IDX_W-1:0]       req_set_index,
   input  logic [fcr_pkg::WAYF_W-1:0]      req_way,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fcr_pkg::WAYF_W-1:0]      rsp_victim_way
);

   localparam int ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W  = $clog2(WAYS);
   localparam int ROW_W  = WAYS * WAY_W;

   logic [ADDR_W-1:0]              clr_cnt_ff, clr_cnt_in;
   logic [fcr_pkg::FUNC_W-1:0]     func_ff;
   logic [ADDR_W-1:0]              set_ff;
   logic [WAY_W-1:0]               way_ff;
   logic                           set_oor_ff;
   logic                           way_ok_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [fcr_pkg::WAYF_W-1:0]     victim_ff;

   logic [ROW_W-1:0]               init_row;
   logic [ROW_W-1:0]               old_row;
   logic [ROW_W-1:0]               new_row;
   logic                           found;

   logic                           ram_we;
   logic [ADDR_W-1:0]              ram_waddr;
   logic [ROW_W-1:0]               ram_wdata;

   // reset contents of a row: position j holds way j
   for (genvar j = 0; j < WAYS; j++) begin : g_init
      assign init_row[j*WAY_W +: WAY_W] = WAY_W'(j);
   end

   // clearing pass counter
   assign clr_cnt_in = cmd.clear_step ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign status.clear_last = (clr_cnt_ff == ADDR_W'(NUM_SETS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // request capture while the row is read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         set_ff     <= ADDR_W'(req_set_index);
         way_ff     <= WAY_W'(req_way);
         set_oor_ff <= (32'(req_set_index) >= NUM_SETS);
         way_ok_ff  <= (32'(req_way) < WAYS);
      end
   end

   // move the evicted way to the back, later entries shift forward
   always_comb begin
      found   = 1'b0;
      new_row = old_row;
      for (int p = 0; p < WAYS - 1; p++) begin
         found = found | (old_row[p*WAY_W +: WAY_W] == way_ff);
         if (found) begin
            new_row[p*WAY_W +: WAY_W] = old_row[(p+1)*WAY_W +: WAY_W];
         end
      end
      found = found | (old_row[(WAYS-1)*WAY_W +: WAY_W] == way_ff);
      if (found) begin
         new_row[(WAYS-1)*WAY_W +: WAY_W] = way_ff;
      end
   end

   // ram write: clearing pass or eviction write-back
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = set_ff;
      ram_wdata = new_row;
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = init_row;
      end else if (cmd.update && (func_ff == fcr_pkg::FUNC_EVICT) &&
                   !set_oor_ff && way_ok_ff) begin
         ram_we = 1'b1;
      end
   end

   fcr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS),
      .ADDR_W(ADDR_W)
   ) u_order_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (cmd.capture),
      .raddr(ADDR_W'(req_set_index)),
      .rdata(old_row)
   );

   // result register
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // front of the updated row, zero for a set out of range
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (set_oor_ff) begin
            victim_ff <= '0;
         end else if ((func_ff == fcr_pkg::FUNC_EVICT) && way_ok_ff) begin
            victim_ff <= fcr_pkg::WAYF_W'(new_row[WAY_W-1:0]);
         end else begin
            victim_ff <= fcr_pkg::WAYF_W'(old_row[WAY_W-1:0]);
         end
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_victim_way = victim_ff;

endmodule
